// ===== src/mahr_pkg.sv =====
// Shared types and codes for the multichannel audio history ring.
// Holds operation codes and the controller/datapath command and status words.
// No dependencies.
`default_nettype none

package mahr_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic write;
    logic clear_init;
    logic clear_step;
    logic read_load;
    logic read_step;
    logic emit_error;
  } mahr_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic read_last;
    logic clear_done;
  } mahr_sts_t;

endpackage

`default_nettype wire

// ===== src/mahr_ctrl.sv =====
// Controller state machine of the history ring: sequences writes, reads and clears.
// Depends on mahr_pkg for operation codes and the command/status words.
`default_nettype none

module mahr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [1:0]           op,
  input  wire mahr_pkg::mahr_sts_t  sts,
  output logic                      busy,
  output mahr_pkg::mahr_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            mahr_pkg::OP_WRITE: begin
              cmd.write = 1'b1;
            end
            mahr_pkg::OP_CLEAR: begin
              cmd.clear_init = 1'b1;
              state_next     = ST_CLEAR;
            end
            mahr_pkg::OP_READ: begin
              if (sts.req_ok) begin
                cmd.read_load = 1'b1;
                state_next    = ST_READ;
              end else begin
                cmd.emit_error = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.read_step = 1'b1;
        if (sts.read_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mahr_dp.sv =====
// Datapath of the history ring: sample memory, write position, read walker, result word.
// Depends on mahr_pkg for the command/status words; driven by mahr_ctrl.
`default_nettype none

module mahr_dp #(
  parameter int NUM_CHANNELS = 4,
  parameter int MAX_LEN      = 1024,
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mahr_pkg::mahr_cmd_t  cmd,
  input  wire logic [1:0]           channel,
  input  wire logic signed [15:0]   sample,
  input  wire logic                 advance,
  input  wire logic [9:0]           window_start,
  input  wire logic [9:0]           window_end,
  output mahr_pkg::mahr_sts_t       sts,
  output logic                      strobe,
  output logic signed [15:0]        data,
  output logic                      last,
  output logic                      status
);

  localparam int PW    = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam int CW    = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = 2 ** AW;
  localparam int FW    = ((PW > 10) ? PW : 10) + 1;
  localparam int LW    = $clog2(MAX_WINDOW + 1);

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]           pos;
  logic [AW-1:0]           clr_addr;
  logic [CW-1:0]           rd_ch;
  logic [PW-1:0]           rd_pos;
  logic [LW-1:0]           remaining;
  logic [SAMPLE_WIDTH-1:0] rd_q;

  logic [CW-1:0]           ch_idx;
  logic                    ch_ok;
  logic [9:0]              len;
  logic [FW-1:0]           first_wide;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [SAMPLE_WIDTH-1:0] wdata;

  assign ch_idx = CW'(channel);
  assign ch_ok  = 32'(channel) < 32'(NUM_CHANNELS);
  assign len    = window_start - window_end;

  always_comb begin
    if (FW'(pos) >= FW'(window_start)) begin
      first_wide = FW'(pos) - FW'(window_start);
    end else begin
      first_wide = FW'(pos) + FW'(MAX_LEN) - FW'(window_start);
    end
  end

  assign sts.req_ok = ch_ok && (window_start > window_end)
                   && (32'(window_start) < 32'(MAX_LEN))
                   && (32'(len) <= 32'(MAX_WINDOW));
  assign sts.read_last  = (remaining == LW'(1));
  assign sts.clear_done = (clr_addr == {AW{1'b1}});

  assign we    = cmd.clear_step || (cmd.write && ch_ok);
  assign waddr = cmd.clear_step ? clr_addr : {ch_idx, pos};
  assign wdata = cmd.clear_step ? '0 : SAMPLE_WIDTH'($unsigned(sample));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[{rd_ch, rd_pos}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_init) begin
        pos      <= '0;
        clr_addr <= '0;
      end else if (cmd.write && advance) begin
        pos <= (pos == PW'(MAX_LEN - 1)) ? '0 : pos + PW'(1);
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_load) begin
      rd_ch     <= ch_idx;
      rd_pos    <= PW'(first_wide);
      remaining <= LW'(len);
    end else if (cmd.read_step) begin
      rd_pos    <= (rd_pos == PW'(MAX_LEN - 1)) ? '0 : rd_pos + PW'(1);
      remaining <= remaining - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
      status <= 1'b0;
    end else begin
      strobe <= cmd.read_step || cmd.emit_error;
      last   <= (cmd.read_step && sts.read_last) || cmd.emit_error;
      status <= cmd.emit_error;
    end
  end

  assign data = status ? '0 : $signed(16'(rd_q));

endmodule

`default_nettype wire

// ===== src/multichannel_audio_history_ring.sv =====
// Top level of the multichannel audio history ring: controller plus datapath.
// Depends on mahr_pkg, mahr_ctrl and mahr_dp.
// Write: one word per cycle, busy stays low. Read: busy for len cycles, one result a cycle,
// the first on the second cycle after acceptance; an invalid window gives one error word on
// the cycle right after acceptance, busy stays low. Clear and reset: the memory sweep writes
// one entry a cycle, busy for 2**(clog2(NUM_CHANNELS)+clog2(MAX_LEN)) cycles (4096 by default).
`default_nettype none

module multichannel_audio_history_ring #(
  parameter int NUM_CHANNELS = 4,
  parameter int MAX_LEN      = 1024,
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op,
  input  wire logic [1:0]         channel,
  input  wire logic signed [15:0] sample,
  input  wire logic               advance,
  input  wire logic [9:0]         window_start,
  input  wire logic [9:0]         window_end,
  output logic                    strobe,
  output logic signed [15:0]      data,
  output logic                    last,
  output logic                    status
);

  mahr_pkg::mahr_cmd_t cmd;
  mahr_pkg::mahr_sts_t sts;

  mahr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  mahr_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_LEN      (MAX_LEN),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .channel      (channel),
    .sample       (sample),
    .advance      (advance),
    .window_start (window_start),
    .window_end   (window_end),
    .sts          (sts),
    .strobe       (strobe),
    .data         (data),
    .last         (last),
    .status       (status)
  );

endmodule

`default_nettype wire
